@@ hdl/trle_pkg.sv @@
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the tile run-length expander: field
// positions of the code byte, result status codes, and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package trle_pkg;

    localparam int CODE_W   = 8;
    localparam int REP_W    = 3;
    localparam int REP_LSB  = 5;
    localparam int PAL_BIT  = 4;
    localparam int TILE_W   = 4;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] WIDTH_RESET = COUNT_W'(1);

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_REPEAT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT   = 2'd2;

    typedef struct packed {
        logic accept;
        logic emit;
    } trle_cmd_t;

    typedef struct packed {
        logic left_nz;
        logic left_one;
    } trle_stat_t;

endpackage

@@ hdl/trle_ctrl.sv @@
// ----------------------------------------------------------------------------
// trle_ctrl
// Controller: takes one code byte in idle, then steps the datapath through
// its tile results one per cycle as the output register frees up.
// ----------------------------------------------------------------------------
module trle_ctrl
    import trle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  trle_stat_t dp_stat,
    output trle_cmd_t  dp_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        dp_cmd.accept = 1'b0;
        dp_cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!dp_stat.left_nz)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    dp_cmd.emit = 1'b1;
                    if (dp_stat.left_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/trle_dp.sv @@
// ----------------------------------------------------------------------------
// trle_dp
// Datapath: row width register, saturating row tile counter, discard flag,
// pending run registers and the output result register.
// ----------------------------------------------------------------------------
module trle_dp
    import trle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic [CODE_W-1:0]     code_byte,
    input  logic                  row_last_byte,
    input  trle_cmd_t             dp_cmd,
    output trle_stat_t            dp_stat,
    output logic [TILE_W-1:0]     tile_index,
    output logic                  palette_select,
    output logic                  run_last,
    output logic                  row_end,
    output logic [STATUS_W-1:0]   status
);

    logic [COUNT_W-1:0]  width_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                discard_reg;
    logic                discard_next;
    logic [REP_W-1:0]    left_reg;
    logic [REP_W-1:0]    left_next;
    logic [TILE_W-1:0]   tile_reg;
    logic [TILE_W-1:0]   tile_next;
    logic                pal_reg;
    logic                pal_next;
    logic                last_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic [TILE_W-1:0]   out_tile_reg;
    logic                out_pal_reg;
    logic                out_run_last_reg;
    logic                out_row_end_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [REP_W-1:0]    rep;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  sat_count;

    assign rep       = code_byte[REP_LSB +: REP_W];
    assign sum       = {1'b0, count_reg} + (COUNT_W+1)'(rep);
    assign sat_count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

    assign dp_stat.left_nz  = (left_reg != '0);
    assign dp_stat.left_one = (left_reg == REP_W'(1));

    always_comb
    begin
        count_next   = count_reg;
        discard_next = discard_reg;
        left_next    = left_reg;
        tile_next    = tile_reg;
        pal_next     = pal_reg;
        status_next  = status_reg;
        if (dp_cmd.accept)
        begin
            if (discard_reg)
            begin
                tile_next   = '0;
                pal_next    = 1'b0;
                status_next = STATUS_ZERO_REPEAT;
                if (row_last_byte)
                begin
                    left_next    = REP_W'(1);
                    count_next   = '0;
                    discard_next = 1'b0;
                end
                else
                begin
                    left_next = '0;
                end
            end
            else if (rep == '0)
            begin
                tile_next   = '0;
                pal_next    = 1'b0;
                status_next = STATUS_ZERO_REPEAT;
                left_next   = REP_W'(1);
                if (row_last_byte)
                begin
                    count_next = '0;
                end
                else
                begin
                    discard_next = 1'b1;
                end
            end
            else
            begin
                tile_next   = code_byte[TILE_W-1:0];
                pal_next    = code_byte[PAL_BIT];
                left_next   = rep;
                status_next = (row_last_byte && (sat_count != width_reg)) ?
                              STATUS_BAD_COUNT : STATUS_OK;
                count_next  = row_last_byte ? '0 : sat_count;
            end
        end
        else if (dp_cmd.emit)
        begin
            left_next = left_reg - REP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            count_reg   <= '0;
            discard_reg <= 1'b0;
            left_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_data;
            end
            count_reg   <= count_next;
            discard_reg <= discard_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg   <= tile_next;
        pal_reg    <= pal_next;
        status_reg <= status_next;
        if (dp_cmd.accept)
        begin
            last_reg <= row_last_byte;
        end
        if (dp_cmd.emit)
        begin
            out_tile_reg     <= tile_reg;
            out_pal_reg      <= pal_reg;
            out_run_last_reg <= dp_stat.left_one;
            out_row_end_reg  <= dp_stat.left_one && last_reg;
            out_status_reg   <= dp_stat.left_one ? status_reg : STATUS_OK;
        end
    end

    assign tile_index     = out_tile_reg;
    assign palette_select = out_pal_reg;
    assign run_last       = out_run_last_reg;
    assign row_end        = out_row_end_reg;
    assign status         = out_status_reg;

endmodule

@@ hdl/tile_run_length_expander_unit.sv @@
// ----------------------------------------------------------------------------
// tile_run_length_expander_unit
// Expands run-length coded map row bytes into tile results with row checks.
// ----------------------------------------------------------------------------
// Each accepted code byte is taken in while idle, then hands over one tile per
// cycle while the output register is free: n tiles for a repeat count n (1 to
// 7), one for a zero-repeat byte, none for a discarded byte unless it is the
// last byte of its row. The single output register paces the tiles. A byte
// is not taken while the previous byte still has tiles left to hand over,
// but it is taken while the last tile waits in the output register.
// row_width may only be written while no byte is in progress.
module tile_run_length_expander_unit
    import trle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,        // row_width
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CODE_W-1:0]     s_axis_tdata,    // [7:0] code_byte
    input  logic                  s_axis_tlast,    // row_last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,    // [3:0] tile_index, [4] palette_select
    output logic [OUT_USER_W-1:0] m_axis_tuser,    // [0] run_last, [2:1] status
    output logic                  m_axis_tlast     // row_end
);

    trle_cmd_t           dp_cmd;
    trle_stat_t          dp_stat;
    logic [TILE_W-1:0]   tile_index;
    logic                palette_select;
    logic                run_last;
    logic [STATUS_W-1:0] status;

    assign cfg_ready = 1'b1;

    trle_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    trle_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .code_byte      (s_axis_tdata),
        .row_last_byte  (s_axis_tlast),
        .dp_cmd         (dp_cmd),
        .dp_stat        (dp_stat),
        .tile_index     (tile_index),
        .palette_select (palette_select),
        .run_last       (run_last),
        .row_end        (m_axis_tlast),
        .status         (status)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-TILE_W-1){1'b0}}, palette_select, tile_index};
    assign m_axis_tuser = {status, run_last};

    // no tiles pending while a new transaction can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !dp_stat.left_nz)
        else $error("tiles pending while input is ready");

    // input ready is low in the cycle after a taken transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // row end only on the last tile of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("row end without run last");

    // a non-ok status only on the last tile of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] != STATUS_OK)) |-> m_axis_tuser[0])
        else $error("error status on a tile that is not run last");

endmodule

@@ verif/tile_expand_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_expand_checker
// Watches the configuration, code byte and tile channels of the tile run-length
// expander, keeps its own copy of the row state, predicts the tiles each code
// byte produces and compares every tile transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tile_expand_checker
    import trle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [CODE_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int unsigned           mismatches,
    output int unsigned           tiles_pending
);

    typedef struct packed {
        logic [TILE_W-1:0]   tile;
        logic                palette;
        logic                run_last;
        logic                row_end;
        logic [STATUS_W-1:0] status;
    } tile_result_t;

    tile_result_t       expected_tiles[$];
    logic [COUNT_W-1:0] row_width_q;
    logic [COUNT_W-1:0] tile_count_q;
    logic               discarding_q;
    int unsigned        errors_seen = 0;
    int unsigned        pending_q = 0;
    tile_result_t       want;
    tile_result_t       got;

    assign mismatches    = errors_seen;
    assign tiles_pending = pending_q;

    function automatic void push_tile(input logic [TILE_W-1:0] tile, input logic palette,
                                      input logic run_last, input logic row_end,
                                      input logic [STATUS_W-1:0] status);
        tile_result_t r;
        r.tile     = tile;
        r.palette  = palette;
        r.run_last = run_last;
        r.row_end  = row_end;
        r.status   = status;
        expected_tiles = {expected_tiles, r};
    endfunction

    function automatic void expand_code_byte(input logic [CODE_W-1:0] code,
                                             input logic row_last);
        logic [REP_W-1:0]    rep;
        logic [COUNT_W:0]    sum;
        logic [STATUS_W-1:0] end_status;
        rep = code[REP_LSB +: REP_W];
        if (discarding_q)
        begin
            if (row_last)
            begin
                push_tile('0, 1'b0, 1'b1, 1'b1, STATUS_ZERO_REPEAT);
                tile_count_q = '0;
                discarding_q = 1'b0;
            end
            return;
        end
        if (rep == '0)
        begin
            push_tile('0, 1'b0, 1'b1, row_last, STATUS_ZERO_REPEAT);
            if (row_last)
                tile_count_q = '0;
            else
                discarding_q = 1'b1;
            return;
        end
        // saturating per-row tile count
        sum = {1'b0, tile_count_q} + rep;
        tile_count_q = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
        end_status = (row_last && tile_count_q != row_width_q) ? STATUS_BAD_COUNT : STATUS_OK;
        for (int k = 1; k <= rep; k++)
            push_tile(code[TILE_W-1:0], code[PAL_BIT], k == rep, (k == rep) && row_last,
                      (k == rep) ? end_status : STATUS_OK);
        if (row_last)
        begin
            tile_count_q = '0;
            discarding_q = 1'b0;
        end
    endfunction

    task automatic report_tile(input string what, input tile_result_t w, input tile_result_t g);
        errors_seen++;
        if (errors_seen <= 10)
            $display("%0t %s: expected %h %b %b %b %0d, actual %h %b %b %b %0d",
                     $realtime, what, w.tile, w.palette, w.run_last, w.row_end, w.status,
                     g.tile, g.palette, g.run_last, g.row_end, g.status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_q  = WIDTH_RESET;
            tile_count_q = '0;
            discarding_q = 1'b0;
            expected_tiles.delete();
            pending_q    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_width_q = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expand_code_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.tile     = m_axis_tdata[TILE_W-1:0];
                got.palette  = m_axis_tdata[TILE_W];
                got.run_last = m_axis_tuser[0];
                got.status   = m_axis_tuser[2:1];
                got.row_end  = m_axis_tlast;
                if (expected_tiles.size() == 0)
                    report_tile("tile with nothing pending", '0, got);
                else
                begin
                    want = expected_tiles.pop_front();
                    if (got !== want)
                        report_tile("tile mismatch", want, got);
                end
            end
            pending_q = expected_tiles.size();
        end
    end

endmodule

@@ verif/tile_run_length_expander_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_run_length_expander_unit_tb
// Drives map rows of run-length code bytes into the expander under several
// row widths: directed rows for the status cases, a long output stall, then
// random well-formed and broken rows with random idling on both channels.
// A separate checker scores the tiles.
// ----------------------------------------------------------------------------
module tile_run_length_expander_unit_tb;
    import trle_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CODE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    int unsigned        mismatches;
    int unsigned        tiles_pending;
    bit                 quiet = 1'b0;
    bit                 hold_request = 1'b0;
    int unsigned        bytes_sent = 0;
    logic [COUNT_W-1:0] row_width = WIDTH_RESET;

    tile_run_length_expander_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tile_expand_checker u_tile_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .tiles_pending (tiles_pending)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("tile_run_length_expander_unit_tb NOT OK");
        $finish;
    end

    // tile receiver: random stalls, one long hold-off on request
    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                hold_request = 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_code(input logic [CODE_W-1:0] code, input logic row_last);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= row_last;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // wait until every predicted tile is out, plus room for a discarded byte
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tiles_pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [COUNT_W-1:0] width);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= width;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        row_width = width;
    endtask

    // row whose runs add up to the given tile total
    task automatic send_counted_row(input int unsigned total);
        int unsigned left;
        int unsigned rep;
        left = total;
        while (left > 0)
        begin
            rep = $urandom_range(1, (left < 7) ? left : 7);
            left -= rep;
            send_code({3'(rep), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))}, left == 0);
        end
    endtask

    task automatic send_noise_row();
        int unsigned n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_code(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    initial
    begin
        int unsigned random_start;
        int unsigned kind;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset row width of one
        send_code(8'h20, 1'b1);
        send_code(8'h4F, 1'b1);

        write_row_width(16'd12);
        send_code(8'hFF, 1'b0);
        send_code(8'hA0, 1'b1);
        // zero repeat mid row, then discarded bytes up to row end
        send_code(8'h1F, 1'b0);
        send_code(8'hE5, 1'b0);
        send_code(8'h00, 1'b0);
        send_code(8'h3A, 1'b1);
        // zero repeat on the last byte beats the count check
        send_code(8'h6C, 1'b0);
        send_code(8'h10, 1'b1);
        send_code(8'h00, 1'b1);
        // short and long rows
        send_code(8'h2A, 1'b1);
        send_code(8'hEF, 1'b0);
        send_code(8'hD3, 1'b1);
        send_code(8'h87, 1'b0);
        send_code(8'h59, 1'b0);
        send_code(8'hD6, 1'b1);

        write_row_width(COUNT_MAX);
        send_code(8'hF5, 1'b1);

        // long output stall while bytes keep coming
        write_row_width(16'd63);
        hold_request = 1'b1;
        repeat (3) send_counted_row(63);

        random_start = bytes_sent;
        while (bytes_sent - random_start < 90)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       write_row_width(COUNT_MAX);
                    1:       write_row_width(16'd1);
                    2:       write_row_width(16'($urandom_range(1, 65535)));
                    default: write_row_width(16'($urandom_range(2, 40)));
                endcase
            end
            if (bytes_sent - random_start >= 70)
                quiet = 1'b1;
            kind = $urandom_range(0, 9);
            if (row_width > 40 || kind >= 8)
                send_noise_row();
            else if (kind == 6)
                send_counted_row(row_width + $urandom_range(1, 3));
            else if (kind == 7 && row_width > 1)
                send_counted_row(row_width - 1);
            else
                send_counted_row(row_width);
        end

        settle_block();
        if (mismatches == 0 && tiles_pending == 0)
            $display("tile_run_length_expander_unit_tb OK");
        else
            $display("tile_run_length_expander_unit_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/trle_pkg.sv
hdl/trle_ctrl.sv
hdl/trle_dp.sv
hdl/tile_run_length_expander_unit.sv
verif/tile_expand_checker.sv
verif/tile_run_length_expander_unit_tb.sv
